/* hw/rtl/oanav_pkg.sv */
// Shared types and constants for the obstacle-avoid navigation sequencer.
`default_nettype none
package oanav_pkg;

    localparam int SENSOR_COUNT = 5;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [15:0] START_DELAY_RESET = 16'd1000;
    localparam logic [15:0] TURN_TIME_RESET   = 16'd500;
    localparam logic [15:0] REVERSE_TIME_RESET = 16'd500;
    localparam logic [2:0]  REVERSE_MIN_RESET = 3'd4;

    localparam logic signed [7:0] SPEED_FAST      = 8'sd80;
    localparam logic signed [7:0] SPEED_FAST_BACK = -8'sd80;
    localparam logic signed [7:0] SPEED_SLOW_BACK = -8'sd75;
    localparam logic signed [7:0] SPEED_STOP      = 8'sd0;

    localparam logic [1:0] CFG_START_DELAY  = 2'd0;
    localparam logic [1:0] CFG_TURN_TIME    = 2'd1;
    localparam logic [1:0] CFG_REVERSE_TIME = 2'd2;
    localparam logic [1:0] CFG_REVERSE_MIN  = 2'd3;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_FRONT = 2'd1,
        CLS_LEFT  = 2'd2,
        CLS_RIGHT = 2'd3
    } obstacle_class_t;

    typedef enum logic [3:0] {
        ST_WAIT       = 4'd0,
        ST_WAITING    = 4'd1,
        ST_FWD        = 4'd2,
        ST_FWDING     = 4'd3,
        ST_ARC_L      = 4'd4,
        ST_ARC_L_RUN  = 4'd5,
        ST_ARC_R      = 4'd6,
        ST_ARC_R_RUN  = 4'd7,
        ST_SPIN_L     = 4'd8,
        ST_SPIN_L_RUN = 4'd9,
        ST_SPIN_R     = 4'd10,
        ST_SPIN_R_RUN = 4'd11,
        ST_BACK       = 4'd12,
        ST_BACK_RUN   = 4'd13
    } nav_state_t;

    typedef struct packed {
        obstacle_class_t obstacle_class;
        logic [2:0]      active_count;
        logic [31:0]     now_ms;
        logic            restart;
    } nav_item_t;

endpackage
`default_nettype wire

/* hw/rtl/oanav_front.sv */
// Front stage: accepts updates, classifies the sensor mask and registers the result.
`default_nettype none
module oanav_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [4:0]              ir_mask,
    input  wire logic [31:0]             now_ms,
    input  wire logic                    restart,
    output logic                         item_valid,
    input  wire logic                    item_ready,
    output oanav_pkg::nav_item_t         item
);

    function automatic logic [2:0] count_ones(input logic [4:0] m);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < oanav_pkg::SENSOR_COUNT; i++)
        begin
            n = n + {2'b00, m[i]};
        end
        return n;
    endfunction

    function automatic oanav_pkg::obstacle_class_t classify(input logic [4:0] m);
        logic [1:0] lc;
        logic [1:0] rc;
        oanav_pkg::obstacle_class_t c;
        lc = {1'b0, m[4]} + {1'b0, m[3]};
        rc = {1'b0, m[1]} + {1'b0, m[0]};
        unique case (m) inside
            5'b00000:
                c = oanav_pkg::CLS_NONE;
            5'b00100, 5'b01100, 5'b00110, 5'b01110, 5'b11100, 5'b00111, 5'b11111:
                c = oanav_pkg::CLS_FRONT;
            5'b10000, 5'b01000, 5'b11000, 5'b10001, 5'b01010:
                c = oanav_pkg::CLS_LEFT;
            5'b00001, 5'b00010, 5'b00011:
                c = oanav_pkg::CLS_RIGHT;
            default:
            begin
                if (m[2])
                    c = oanav_pkg::CLS_FRONT;
                else if (lc > rc)
                    c = oanav_pkg::CLS_LEFT;
                else if (rc > lc)
                    c = oanav_pkg::CLS_RIGHT;
                else if (m[4])
                    c = oanav_pkg::CLS_LEFT;
                else
                    c = oanav_pkg::CLS_RIGHT;
            end
        endcase
        return c;
    endfunction

    logic                 valid_reg;
    oanav_pkg::nav_item_t item_reg;
    logic                 accept;

    assign in_ready = !valid_reg || item_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.obstacle_class <= classify(ir_mask);
            item_reg.active_count   <= count_ones(ir_mask);
            item_reg.now_ms         <= now_ms;
            item_reg.restart        <= restart;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

/* hw/rtl/oanav_queue.sv */
// Short FIFO between the classifying front stage and the sequencer.
`default_nettype none
module oanav_queue #(
    parameter int DEPTH = oanav_pkg::QUEUE_DEPTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push_valid,
    output logic                         push_ready,
    input  wire oanav_pkg::nav_item_t    push_item,
    output logic                         pop_valid,
    input  wire logic                    pop_ready,
    output oanav_pkg::nav_item_t         pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    oanav_pkg::nav_item_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic push;
    logic pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/oanav_back.sv */
// Back stage: navigation state machine, timing registers and output register.
`default_nettype none
module oanav_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [15:0]             cfg_data,
    input  wire logic                    item_valid,
    output logic                         item_ready,
    input  wire oanav_pkg::nav_item_t    item,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [3:0]                   nav_state,
    output logic [1:0]                   obstacle_class,
    output logic                         drive_update,
    output logic signed [7:0]            left_wheel_pct,
    output logic signed [7:0]            right_wheel_pct,
    output logic                         motor_init
);

    logic [15:0] start_delay_reg;
    logic [15:0] turn_time_reg;
    logic [15:0] reverse_time_reg;
    logic [2:0]  reverse_min_reg;

    oanav_pkg::nav_state_t state_reg;
    oanav_pkg::nav_state_t state_next;
    oanav_pkg::nav_state_t state_cur;
    logic [31:0] phase_start_reg;
    logic [31:0] elapsed;
    logic        take;
    logic        load_phase;
    logic        drive;
    logic        init;
    logic signed [7:0] ls;
    logic signed [7:0] rs;

    logic              out_valid_reg;
    logic [3:0]        nav_state_reg;
    logic [1:0]        class_reg;
    logic              drive_reg;
    logic signed [7:0] left_reg;
    logic signed [7:0] right_reg;
    logic              init_reg;

    assign item_ready = !out_valid_reg || out_ready;
    assign take       = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_reg  <= oanav_pkg::START_DELAY_RESET;
            turn_time_reg    <= oanav_pkg::TURN_TIME_RESET;
            reverse_time_reg <= oanav_pkg::REVERSE_TIME_RESET;
            reverse_min_reg  <= oanav_pkg::REVERSE_MIN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                oanav_pkg::CFG_START_DELAY:  start_delay_reg  <= cfg_data;
                oanav_pkg::CFG_TURN_TIME:    turn_time_reg    <= cfg_data;
                oanav_pkg::CFG_REVERSE_TIME: reverse_time_reg <= cfg_data;
                oanav_pkg::CFG_REVERSE_MIN:  reverse_min_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign state_cur = item.restart ? oanav_pkg::ST_WAIT : state_reg;
    assign elapsed   = item.now_ms - phase_start_reg;

    always_comb
    begin
        state_next = state_cur;
        load_phase = 1'b0;
        drive      = 1'b0;
        init       = 1'b0;
        ls         = oanav_pkg::SPEED_STOP;
        rs         = oanav_pkg::SPEED_STOP;
        unique case (state_cur)
            oanav_pkg::ST_WAIT:
            begin
                load_phase = 1'b1;
                init       = 1'b1;
                state_next = oanav_pkg::ST_WAITING;
            end
            oanav_pkg::ST_WAITING:
            begin
                if (elapsed > {16'b0, start_delay_reg})
                    state_next = oanav_pkg::ST_FWD;
            end
            oanav_pkg::ST_FWD:
            begin
                drive      = 1'b1;
                ls         = oanav_pkg::SPEED_FAST;
                rs         = oanav_pkg::SPEED_FAST;
                load_phase = 1'b1;
                state_next = oanav_pkg::ST_FWDING;
            end
            oanav_pkg::ST_FWDING:
            begin
                case (item.obstacle_class)
                    oanav_pkg::CLS_FRONT:
                        state_next = (item.active_count >= reverse_min_reg) ?
                                     oanav_pkg::ST_BACK : oanav_pkg::ST_SPIN_L;
                    oanav_pkg::CLS_LEFT:
                        state_next = oanav_pkg::ST_ARC_R;
                    oanav_pkg::CLS_RIGHT:
                        state_next = oanav_pkg::ST_ARC_L;
                    default:
                    begin
                        drive = 1'b1;
                        ls    = oanav_pkg::SPEED_FAST;
                        rs    = oanav_pkg::SPEED_FAST;
                    end
                endcase
            end
            oanav_pkg::ST_ARC_L:
            begin
                drive      = 1'b1;
                ls         = oanav_pkg::SPEED_SLOW_BACK;
                rs         = oanav_pkg::SPEED_FAST;
                load_phase = 1'b1;
                state_next = oanav_pkg::ST_ARC_L_RUN;
            end
            oanav_pkg::ST_ARC_R:
            begin
                drive      = 1'b1;
                ls         = oanav_pkg::SPEED_FAST;
                rs         = oanav_pkg::SPEED_SLOW_BACK;
                load_phase = 1'b1;
                state_next = oanav_pkg::ST_ARC_R_RUN;
            end
            oanav_pkg::ST_SPIN_L:
            begin
                drive      = 1'b1;
                ls         = oanav_pkg::SPEED_FAST_BACK;
                rs         = oanav_pkg::SPEED_FAST;
                load_phase = 1'b1;
                state_next = oanav_pkg::ST_SPIN_L_RUN;
            end
            oanav_pkg::ST_SPIN_R:
            begin
                drive      = 1'b1;
                ls         = oanav_pkg::SPEED_FAST;
                rs         = oanav_pkg::SPEED_FAST_BACK;
                load_phase = 1'b1;
                state_next = oanav_pkg::ST_SPIN_R_RUN;
            end
            oanav_pkg::ST_ARC_L_RUN, oanav_pkg::ST_ARC_R_RUN,
            oanav_pkg::ST_SPIN_L_RUN, oanav_pkg::ST_SPIN_R_RUN:
            begin
                if (elapsed > {16'b0, turn_time_reg})
                    state_next = oanav_pkg::ST_FWD;
            end
            oanav_pkg::ST_BACK:
            begin
                drive      = 1'b1;
                ls         = oanav_pkg::SPEED_FAST_BACK;
                rs         = oanav_pkg::SPEED_FAST_BACK;
                load_phase = 1'b1;
                state_next = oanav_pkg::ST_BACK_RUN;
            end
            oanav_pkg::ST_BACK_RUN:
            begin
                if (elapsed > {16'b0, reverse_time_reg})
                    state_next = oanav_pkg::ST_SPIN_L;
            end
            default:
            begin
                // unused codes: stop and restart
                drive      = 1'b1;
                state_next = oanav_pkg::ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= oanav_pkg::ST_WAIT;
            phase_start_reg <= '0;
        end
        else if (take)
        begin
            state_reg <= state_next;
            if (load_phase)
                phase_start_reg <= item.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (item_ready)
            out_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            nav_state_reg <= state_next;
            class_reg     <= item.obstacle_class;
            drive_reg     <= drive;
            left_reg      <= ls;
            right_reg     <= rs;
            init_reg      <= init;
        end
    end

    assign out_valid       = out_valid_reg;
    assign nav_state       = nav_state_reg;
    assign obstacle_class  = class_reg;
    assign drive_update    = drive_reg;
    assign left_wheel_pct  = left_reg;
    assign right_wheel_pct = right_reg;
    assign motor_init      = init_reg;

    a_take_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("taken transaction did not reach the output register");

    a_idle_speeds_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !drive_reg) |-> (left_reg == 8'sd0 && right_reg == 8'sd0))
        else $error("speeds nonzero without drive update");

    a_init_enters_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && init_reg) |-> (nav_state_reg == oanav_pkg::ST_WAITING))
        else $error("motor init without entering waiting state");

    a_phase_on_drive_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (take && load_phase) |=> (phase_start_reg == $past(item.now_ms)))
        else $error("phase start not captured");

endmodule
`default_nettype wire

/* hw/rtl/obstacle_avoid_navigation_fsm_top.sv */
// Top level of the obstacle-avoid navigation sequencer.
//
// Input channel (in_valid/in_ready) carries one navigation update per
// transaction: ir_mask, now_ms and restart. Output channel
// (out_valid/out_ready) returns exactly one result per update: nav_state,
// obstacle_class, drive_update, left_wheel_pct, right_wheel_pct and motor_init.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// the four timing/threshold registers; cfg_ready is always high. Write it
// only while no update is in flight.
// A result passes through the front classify register, then the queue and
// then the sequencer output register. Throughput: one update per cycle while
// the receiver does not stall, as the sequencer makes one state transition
// per update.
// Reset puts the sequencer in the wait state, clears the phase timer and
// loads the register defaults. When the receiver stalls, the output
// register holds and the queue and front register absorb up to
// QUEUE_DEPTH + 1 further updates before in_ready drops.
`default_nettype none
module obstacle_avoid_navigation_fsm_top #(
    parameter int QUEUE_DEPTH = oanav_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [4:0]         ir_mask,
    input  wire logic [31:0]        now_ms,
    input  wire logic               restart,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [3:0]              nav_state,
    output logic [1:0]              obstacle_class,
    output logic                    drive_update,
    output logic signed [7:0]       left_wheel_pct,
    output logic signed [7:0]       right_wheel_pct,
    output logic                    motor_init
);

    logic                 f_valid;
    logic                 f_ready;
    oanav_pkg::nav_item_t f_item;
    logic                 q_valid;
    logic                 q_ready;
    oanav_pkg::nav_item_t q_item;

    assign cfg_ready = 1'b1;

    oanav_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ir_mask     (ir_mask),
        .now_ms      (now_ms),
        .restart     (restart),
        .item_valid  (f_valid),
        .item_ready  (f_ready),
        .item        (f_item)
    );

    oanav_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    oanav_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (q_valid),
        .item_ready      (q_ready),
        .item            (q_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .nav_state       (nav_state),
        .obstacle_class  (obstacle_class),
        .drive_update    (drive_update),
        .left_wheel_pct  (left_wheel_pct),
        .right_wheel_pct (right_wheel_pct),
        .motor_init      (motor_init)
    );

endmodule
`default_nettype wire
